### src/pap_pkg.sv
package pap_pkg;

  // Tracked window size in pages
  localparam int unsigned NumPages = 4096;
  localparam int unsigned PageIdxW = $clog2(NumPages);

  localparam int unsigned OpW      = 2;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned InsnW    = 16;
  localparam int unsigned CntW     = 13;
  localparam int unsigned StampW   = 64;
  localparam int unsigned InsnTotW = 48;
  localparam int unsigned UntrW    = 32;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned BaseW    = 42;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 42;

  localparam int unsigned MinShift = 6;
  localparam int unsigned MaxShift = 30;
  localparam int unsigned ResetShift = 12;

  // Page number width: last byte of an access can carry one bit past the address
  localparam int unsigned EndW  = AddrW + 1;
  localparam int unsigned PageW = EndW - MinShift;

  typedef enum logic [OpW-1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpPhase = 2'd2,
    OpInsn  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPageShift = 4'd0,
    CfgBasePage  = 4'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAccSetup,
    StAccLoop,
    StPhScan,
    StPhDrain,
    StPhEmit
  } state_e;

endpackage

### src/pap_ram.sv
module pap_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/page_access_phase_profiler.sv
// Page access phase profiler.
// Input channel (in_valid_i / in_stall_o) takes one item per accept: a read or
// write access (address, size), a phase mark, or an instruction count.
// Reads and writes stamp every tracked page they span with the access time;
// a phase mark sweeps the whole stamp table and emits one summary item on the
// output channel (out_valid_o / out_stall_i). Config writes (page_shift,
// base_page) go through cfg_valid_i / cfg_ready_o and are always taken.
// An instruction count is taken in StIdle itself. An access passes StAccSetup,
// then StAccLoop stamps one page per cycle into the stamp RAM of its kind
// (u_rd_ram for reads, u_wr_ram for writes), each with its own write port;
// a phase mark passes StPhScan, reading one table entry per cycle from both
// RAMs, then StPhDrain, then StPhEmit, which loads the output register;
// in_stall_o stays high through all these states. After reset the block zeroes
// both stamp RAMs (in_stall_o high). A stalled summary sits in the output
// register; the next items are still taken, and only a following phase mark waits for it.
module page_access_phase_profiler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pap_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pap_pkg::CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pap_pkg::OpW-1:0]       operation_i,
  input  logic [pap_pkg::AddrW-1:0]     address_i,
  input  logic [pap_pkg::SizeW-1:0]     access_size_i,
  input  logic [pap_pkg::InsnW-1:0]     insn_count_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pap_pkg::CntW-1:0]      ro_pages_o,
  output logic [pap_pkg::CntW-1:0]      rw_pages_o,
  output logic [pap_pkg::CntW-1:0]      wo_pages_o,
  output logic [pap_pkg::CntW-1:0]      total_pages_o,
  output logic [pap_pkg::StampW-1:0]    phase_start_o,
  output logic [pap_pkg::StampW-1:0]    phase_end_o,
  output logic [pap_pkg::InsnTotW-1:0]  insns_in_phase_o,
  output logic [pap_pkg::UntrW-1:0]     untracked_accesses_o
);

  import pap_pkg::*;

  localparam logic [PageIdxW-1:0] LastIdx = PageIdxW'(NumPages - 1);

  // control
  state_e                state_q, state_d;
  logic [PageIdxW-1:0]   idx_q, idx_d;
  logic                  scan_v_q, scan_v_d;
  logic                  out_valid_q, out_valid_d;

  // architectural state
  logic [ShiftW-1:0]     page_shift_q, page_shift_d;
  logic [BaseW-1:0]      base_page_q, base_page_d;
  logic [StampW-1:0]     time_q, time_d;
  logic [StampW-1:0]     mark_q, mark_d;
  logic [InsnTotW-1:0]   insn_q, insn_d;
  logic [UntrW-1:0]      untr_q, untr_d;

  // access working registers
  logic                  is_wr_q, is_wr_d;
  logic [ShiftW-1:0]     sh_q, sh_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [EndW-1:0]       end_q, end_d;
  logic [StampW-1:0]     stamp_q, stamp_d;
  logic [PageW-1:0]      pg_q, pg_d;
  logic [PageW-1:0]      last_q, last_d;
  logic                  outside_q, outside_d;

  // sweep counters
  logic [CntW-1:0]       ro_q, ro_d, rw_q, rw_d, wo_q, wo_d, tot_q, tot_d;

  // output register
  logic [CntW-1:0]       o_ro_q, o_ro_d, o_rw_q, o_rw_d, o_wo_q, o_wo_d, o_tot_q, o_tot_d;
  logic [StampW-1:0]     o_start_q, o_start_d, o_end_q, o_end_d;
  logic [InsnTotW-1:0]   o_insn_q, o_insn_d;
  logic [UntrW-1:0]      o_untr_q, o_untr_d;

  // RAM ports
  logic                  rd_we, wr_we;
  logic [PageIdxW-1:0]   waddr, raddr;
  logic [StampW-1:0]     wdata, rd_stamp, wr_stamp;

  // datapath helpers
  logic                  in_acc;
  logic [ShiftW-1:0]     sh_eff;
  logic [SizeW-1:0]      size_eff;
  logic [PageW:0]        off;
  logic                  pg_out;
  logic [InsnTotW:0]     insn_sum;
  logic                  r_hit, w_hit;

  pap_ram #(.Width(StampW), .Depth(NumPages)) u_rd_ram (
    .clk_i   (clk_i),
    .we_i    (rd_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_stamp)
  );

  pap_ram #(.Width(StampW), .Depth(NumPages)) u_wr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (wr_stamp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Page shift clamp and zero-size fixup
  always_comb begin
    if (page_shift_q < ShiftW'(MinShift)) begin
      sh_eff = ShiftW'(MinShift);
    end else if (page_shift_q > ShiftW'(MaxShift)) begin
      sh_eff = ShiftW'(MaxShift);
    end else begin
      sh_eff = page_shift_q;
    end
    size_eff = (access_size_i == '0) ? SizeW'(1) : access_size_i;
  end

  // Window check: borrow means below base, otherwise compare to window size
  assign off    = {1'b0, pg_q} - (PageW + 1)'(base_page_q);
  assign pg_out = off[PageW] || (off[PageW-1:0] >= PageW'(NumPages));

  assign insn_sum = {1'b0, insn_q} + (InsnTotW + 1)'(insn_count_i);

  // stamp in (lo, hi] is the same as stamp-1 in [lo, hi) with stamp 0 never hit
  assign r_hit = (rd_stamp > mark_q) && (rd_stamp <= time_q);
  assign w_hit = (wr_stamp > mark_q) && (wr_stamp <= time_q);

  assign raddr = idx_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    scan_v_d     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    page_shift_d = page_shift_q;
    base_page_d  = base_page_q;
    time_d       = time_q;
    mark_d       = mark_q;
    insn_d       = insn_q;
    untr_d       = untr_q;
    is_wr_d      = is_wr_q;
    sh_d         = sh_q;
    addr_d       = addr_q;
    end_d        = end_q;
    stamp_d      = stamp_q;
    pg_d         = pg_q;
    last_d       = last_q;
    outside_d    = outside_q;
    ro_d         = ro_q;
    rw_d         = rw_q;
    wo_d         = wo_q;
    tot_d        = tot_q;
    o_ro_d       = o_ro_q;
    o_rw_d       = o_rw_q;
    o_wo_d       = o_wo_q;
    o_tot_d      = o_tot_q;
    o_start_d    = o_start_q;
    o_end_d      = o_end_q;
    o_insn_d     = o_insn_q;
    o_untr_d     = o_untr_q;
    rd_we        = 1'b0;
    wr_we        = 1'b0;
    waddr        = off[PageIdxW-1:0];
    wdata        = stamp_q;

    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPageShift: page_shift_d = cfg_data_i[ShiftW-1:0];
        CfgBasePage:  base_page_d  = cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end

    // Sweep accumulate, one RAM word behind the read address
    if (scan_v_q) begin
      if (r_hit || w_hit) begin
        tot_d = (tot_q == '1) ? tot_q : tot_q + CntW'(1);
      end
      if (r_hit && w_hit) begin
        rw_d = (rw_q == '1) ? rw_q : rw_q + CntW'(1);
      end else if (r_hit) begin
        ro_d = (ro_q == '1) ? ro_q : ro_q + CntW'(1);
      end else if (w_hit) begin
        wo_d = (wo_q == '1) ? wo_q : wo_q + CntW'(1);
      end
    end

    case (state_q)
      StClear: begin
        rd_we = 1'b1;
        wr_we = 1'b1;
        waddr = idx_q;
        wdata = '0;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = StIdle;
        end else begin
          idx_d = idx_q + PageIdxW'(1);
        end
      end

      StIdle: begin
        if (in_acc) begin
          case (op_e'(operation_i))
            OpRead, OpWrite: begin
              is_wr_d   = (op_e'(operation_i) == OpWrite);
              sh_d      = sh_eff;
              addr_d    = address_i;
              end_d     = {1'b0, address_i} + EndW'(size_eff) - EndW'(1);
              stamp_d   = time_q + StampW'(1);
              time_d    = time_q + StampW'(1);
              outside_d = 1'b0;
              state_d   = StAccSetup;
            end
            OpPhase: begin
              time_d  = time_q + StampW'(1);
              idx_d   = '0;
              ro_d    = '0;
              rw_d    = '0;
              wo_d    = '0;
              tot_d   = '0;
              state_d = StPhScan;
            end
            OpInsn: begin
              insn_d = insn_sum[InsnTotW] ? '1 : insn_sum[InsnTotW-1:0];
            end
            default: ;
          endcase
        end
      end

      StAccSetup: begin
        pg_d    = PageW'(addr_q >> sh_q);
        last_d  = PageW'(end_q >> sh_q);
        state_d = StAccLoop;
      end

      StAccLoop: begin
        if (pg_out) begin
          outside_d = 1'b1;
        end else begin
          rd_we = !is_wr_q;
          wr_we = is_wr_q;
        end
        if (pg_q == last_q) begin
          if ((pg_out || outside_q) && (untr_q != '1)) begin
            untr_d = untr_q + UntrW'(1);
          end
          state_d = StIdle;
        end else begin
          pg_d = pg_q + PageW'(1);
        end
      end

      StPhScan: begin
        scan_v_d = 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = StPhDrain;
        end else begin
          idx_d = idx_q + PageIdxW'(1);
        end
      end

      StPhDrain: begin
        state_d = StPhEmit;
      end

      StPhEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_ro_d      = ro_q;
          o_rw_d      = rw_q;
          o_wo_d      = wo_q;
          o_tot_d     = tot_q;
          o_start_d   = mark_q;
          o_end_d     = time_q;
          o_insn_d    = insn_q;
          o_untr_d    = untr_q;
          mark_d      = time_q;
          insn_d      = '0;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      idx_q        <= '0;
      scan_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      page_shift_q <= ShiftW'(ResetShift);
      base_page_q  <= '0;
      time_q       <= '0;
      mark_q       <= '0;
      insn_q       <= '0;
      untr_q       <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      scan_v_q     <= scan_v_d;
      out_valid_q  <= out_valid_d;
      page_shift_q <= page_shift_d;
      base_page_q  <= base_page_d;
      time_q       <= time_d;
      mark_q       <= mark_d;
      insn_q       <= insn_d;
      untr_q       <= untr_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    is_wr_q   <= is_wr_d;
    sh_q      <= sh_d;
    addr_q    <= addr_d;
    end_q     <= end_d;
    stamp_q   <= stamp_d;
    pg_q      <= pg_d;
    last_q    <= last_d;
    outside_q <= outside_d;
    ro_q      <= ro_d;
    rw_q      <= rw_d;
    wo_q      <= wo_d;
    tot_q     <= tot_d;
    o_ro_q    <= o_ro_d;
    o_rw_q    <= o_rw_d;
    o_wo_q    <= o_wo_d;
    o_tot_q   <= o_tot_d;
    o_start_q <= o_start_d;
    o_end_q   <= o_end_d;
    o_insn_q  <= o_insn_d;
    o_untr_q  <= o_untr_d;
  end

  assign out_valid_o          = out_valid_q;
  assign ro_pages_o           = o_ro_q;
  assign rw_pages_o           = o_rw_q;
  assign wo_pages_o           = o_wo_q;
  assign total_pages_o        = o_tot_q;
  assign phase_start_o        = o_start_q;
  assign phase_end_o          = o_end_q;
  assign insns_in_phase_o     = o_insn_q;
  assign untracked_accesses_o = o_untr_q;

endmodule
